// File: hw/rtl/nss_pkg.sv
// Shared types and constants for the naive substring search block.
`default_nettype none
package nss_pkg;

   localparam int MAX_LEN = 64;
   localparam int LEN_W   = $clog2(MAX_LEN + 1);
   localparam int ADDR_W  = $clog2(MAX_LEN);
   localparam int CHAR_W  = 8;

   typedef logic [LEN_W-1:0]  len_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CHAR_W-1:0] char_type;

   localparam char_type NUL_CHAR     = '0;
   localparam logic     MODE_TEXT    = 1'b0;
   localparam logic     MODE_PATTERN = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_COMPARE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic found;
   } status_type;

endpackage
`default_nettype wire

// File: hw/rtl/nss_store.sv
// Character store: one write port, one registered read port.
`default_nettype none
module nss_store (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire nss_pkg::addr_type wr_addr,
   input  wire nss_pkg::char_type wr_data,
   input  wire nss_pkg::addr_type rd_addr,
   output nss_pkg::char_type      rd_data
);
   import nss_pkg::*;

   char_type mem [MAX_LEN];
   char_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: hw/rtl/nss_search.sv
// Search sequencer: walks start positions and pattern offsets through one comparator.
`default_nettype none
module nss_search (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire nss_pkg::len_type  text_len,
   input  wire nss_pkg::len_type  pattern_len,
   input  wire nss_pkg::char_type text_data,
   input  wire nss_pkg::char_type pattern_data,
   output nss_pkg::addr_type      text_addr,
   output nss_pkg::addr_type      pattern_addr,
   output nss_pkg::status_type    status
);
   import nss_pkg::*;

   state_type state_ff, state_in;
   len_type   pos_ff, pos_in;
   len_type   k_ff, k_in;
   logic      found_ff, found_in;
   len_type   addr_sum;
   logic [LEN_W:0] next_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      k_ff     <= k_in;
      found_ff <= found_in;
   end

   assign addr_sum     = pos_ff + k_ff;
   assign text_addr    = addr_sum[ADDR_W-1:0];
   assign pattern_addr = k_ff[ADDR_W-1:0];
   assign next_end     = {1'b0, pos_ff} + {1'b0, pattern_len} + {{LEN_W{1'b0}}, 1'b1};

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      k_in         = k_ff;
      found_in     = found_ff;
      status.busy  = 1'b1;
      status.done  = 1'b0;
      status.found = found_ff;
      unique case (state_ff)
         ST_IDLE: begin
            status.busy = 1'b0;
            pos_in      = '0;
            k_in        = '0;
            found_in    = 1'b0;
            if (start) begin
               if (pattern_len == '0 || pattern_len > text_len) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            if (text_data == pattern_data) begin
               if (k_ff + len_type'(1) == pattern_len) begin
                  found_in = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  k_in     = k_ff + len_type'(1);
                  state_in = ST_FETCH;
               end
            end else if (next_end > {1'b0, text_len}) begin
               state_in = ST_FINISH;
            end else begin
               pos_in   = pos_ff + len_type'(1);
               k_in     = '0;
               state_in = ST_FETCH;
            end
         end
         ST_FINISH: begin
            status.done = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// File: hw/rtl/naive_substring_search.sv
// Top level of the naive substring search block: string loading, result register.
// A text or pattern beat gives no result.
// A pattern terminator runs the search: each byte comparison passes the FETCH and COMPARE
// states through one comparator and the registered store reads, then the result beat waits
// in an output register. No beat is taken during the search, nor a new search while it waits.
// Reset clears lengths, flags and the result valid bit; the result values and the stores hold no reset value.
`default_nettype none
module naive_substring_search (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_mode,
   input  wire nss_pkg::char_type req_ch,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic                   rsp_found,
   output logic                   rsp_overflow
);
   import nss_pkg::*;

   len_type    text_len_ff, pattern_len_ff;
   logic       text_done_ff, over_ff;
   logic       rsp_valid_ff, rsp_found_ff, rsp_overflow_ff;
   logic       accept, is_term, is_search;
   logic       text_wr, pattern_wr;
   addr_type   text_wr_addr;
   addr_type   text_rd_addr, pattern_rd_addr;
   char_type   text_rd_data, pattern_rd_data;
   status_type status;

   assign is_term   = (req_ch == NUL_CHAR);
   assign is_search = (req_mode == MODE_PATTERN) && is_term;
   assign req_ready = !status.busy && !(is_search && rsp_valid_ff);
   assign accept    = req_valid && req_ready;

   assign text_wr = accept && (req_mode == MODE_TEXT) && !is_term
                    && (text_done_ff || text_len_ff < len_type'(MAX_LEN));
   assign text_wr_addr = text_done_ff ? '0 : text_len_ff[ADDR_W-1:0];
   assign pattern_wr = accept && (req_mode == MODE_PATTERN) && !is_term
                       && (pattern_len_ff < len_type'(MAX_LEN));

   always_ff @(posedge clock) begin
      if (reset) begin
         text_len_ff    <= '0;
         pattern_len_ff <= '0;
         text_done_ff   <= 1'b0;
         over_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (status.done) begin
            rsp_valid_ff   <= 1'b1;
            pattern_len_ff <= '0;
         end
         if (accept) begin
            if (req_mode == MODE_TEXT) begin
               if (is_term) begin
                  text_done_ff <= 1'b1;
               end else if (text_done_ff) begin
                  text_done_ff <= 1'b0;
                  text_len_ff  <= len_type'(1);
               end else if (text_len_ff < len_type'(MAX_LEN)) begin
                  text_len_ff <= text_len_ff + len_type'(1);
               end else begin
                  over_ff <= 1'b1;
               end
            end else if (is_term) begin
               over_ff <= 1'b0;
            end else if (pattern_len_ff < len_type'(MAX_LEN)) begin
               pattern_len_ff <= pattern_len_ff + len_type'(1);
            end else begin
               over_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_search) begin
         rsp_overflow_ff <= over_ff;
      end
      if (status.done) begin
         rsp_found_ff <= status.found;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_overflow = rsp_overflow_ff;

   nss_store u_text_store (
      .clock   (clock),
      .wr_en   (text_wr),
      .wr_addr (text_wr_addr),
      .wr_data (req_ch),
      .rd_addr (text_rd_addr),
      .rd_data (text_rd_data)
   );

   nss_store u_pattern_store (
      .clock   (clock),
      .wr_en   (pattern_wr),
      .wr_addr (pattern_len_ff[ADDR_W-1:0]),
      .wr_data (req_ch),
      .rd_addr (pattern_rd_addr),
      .rd_data (pattern_rd_data)
   );

   nss_search u_search (
      .clock        (clock),
      .reset        (reset),
      .start        (accept && is_search),
      .text_len     (text_len_ff),
      .pattern_len  (pattern_len_ff),
      .text_data    (text_rd_data),
      .pattern_data (pattern_rd_data),
      .text_addr    (text_rd_addr),
      .pattern_addr (pattern_rd_addr),
      .status       (status)
   );

endmodule
`default_nettype wire
